@@ rtl/path_to_short_filename_top_macros.svh @@
`ifndef PATH_TO_SHORT_FILENAME_TOP_MACROS_SVH
`define PATH_TO_SHORT_FILENAME_TOP_MACROS_SVH

// trigger in one cycle implies consequent in the next, outside reset
`define PTSF_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

// consequent holds in the cycle after reset is applied
`define PTSF_ASSERT_AFTER_RST(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

@@ rtl/ptsf_pkg.sv @@
package ptsf_pkg;

  localparam int BASE_CHARS  = 8;
  localparam int EXT_CHARS   = 4;
  localparam int TAIL_CHARS  = EXT_CHARS - 1;
  localparam int COUNT_WIDTH = 16;

  localparam int HEAD_IW = (BASE_CHARS > 1) ? $clog2(BASE_CHARS) : 1;
  localparam int HEAD_NW = $clog2(BASE_CHARS + 1);
  localparam int TAIL_IW = (TAIL_CHARS > 1) ? $clog2(TAIL_CHARS) : 1;
  localparam int TAIL_NW = $clog2(TAIL_CHARS + 1);
  localparam int IDX_W   = (HEAD_NW > TAIL_NW) ? HEAD_NW : TAIL_NW;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_ADDR_ALLOW_SPACES = 3'd0;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_LETTER = 2'd1;
  localparam logic [1:0] POS_BODY   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_HEAD,
    S_DOT,
    S_TAIL,
    S_SEP,
    S_DRV_LETTER,
    S_DRV_COLON,
    S_END
  } state_t;

  typedef enum logic [2:0] {
    EM_HEAD,
    EM_DOT,
    EM_TAIL,
    EM_SEP,
    EM_LETTER,
    EM_COLON
  } emit_t;

  typedef struct packed {
    logic             accept;
    logic             emit;
    emit_t            sel;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             clear;
  } ptsf_cmd_t;

  typedef struct packed {
    logic               is_drive;
    logic               is_sep;
    logic               split;
    logic               one;
    logic [HEAD_NW-1:0] n_head;
    logic [TAIL_NW-1:0] n_tail;
    logic               slot_free;
  } ptsf_stat_t;

  function automatic logic [7:0] map_char(input logic [7:0] c, input logic allow);
    logic [7:0] r;
    r = c;
    case (c)
      8'h3A, 8'h3B, 8'h2C, 8'h3D, 8'h2B, 8'h22,
      8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h7C, 8'h09: r = CH_USCORE;
      CH_SPACE: r = allow ? CH_SPACE : CH_USCORE;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] body_char(input logic [7:0] c, input logic allow);
    return map_char((c == CH_DOT) ? CH_USCORE : c, allow);
  endfunction

endpackage

@@ rtl/ptsf_ctrl.sv @@
module ptsf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tlast,
  output logic                 in_tready,
  input  ptsf_pkg::ptsf_stat_t st,
  output ptsf_pkg::ptsf_cmd_t  cmd
);
  import ptsf_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             drive_r, drive_nxt;
  logic             sep_r, sep_nxt;
  logic             fin_r, fin_nxt;
  logic             flush_r, flush_nxt;
  logic             head_end, tail_end, more_tail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      drive_r <= 1'b0;
      sep_r   <= 1'b0;
      fin_r   <= 1'b0;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      drive_r <= drive_nxt;
      sep_r   <= sep_nxt;
      fin_r   <= fin_nxt;
      flush_r <= flush_nxt;
    end
  end

  assign head_end  = (idx_r == IDX_W'(st.n_head - HEAD_NW'(1)));
  assign tail_end  = (idx_r == IDX_W'(st.n_tail - TAIL_NW'(1)));
  assign more_tail = st.split && (st.n_tail != '0);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    drive_nxt = drive_r;
    sep_nxt   = sep_r;
    fin_nxt   = fin_r;
    flush_nxt = flush_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.sel   = EM_HEAD;
    cmd.idx   = idx_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          drive_nxt  = st.is_drive;
          sep_nxt    = st.is_sep;
          fin_nxt    = in_tlast;
          flush_nxt  = !st.is_drive && (st.is_sep || in_tlast);
          state_nxt  = S_START;
        end
      end
      S_START: begin
        idx_nxt = '0;
        if (drive_r)                            state_nxt = S_DRV_LETTER;
        else if (flush_r && st.split)           state_nxt = S_HEAD;
        else if (flush_r && st.one)             state_nxt = S_DOT;
        else if (flush_r && st.n_head != '0)    state_nxt = S_HEAD;
        else if (sep_r)                         state_nxt = S_SEP;
        else                                    state_nxt = S_END;
      end
      S_HEAD: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_HEAD;
          cmd.last = fin_r && !sep_r && !st.split && head_end;
          if (head_end) begin
            if (st.split)  state_nxt = S_DOT;
            else if (sep_r) state_nxt = S_SEP;
            else           state_nxt = S_END;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_DOT: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_DOT;
          cmd.last = fin_r && !sep_r && !more_tail;
          idx_nxt  = '0;
          if (more_tail)  state_nxt = S_TAIL;
          else if (sep_r) state_nxt = S_SEP;
          else            state_nxt = S_END;
        end
      end
      S_TAIL: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_TAIL;
          cmd.last = fin_r && !sep_r && tail_end;
          if (tail_end) state_nxt = sep_r ? S_SEP : S_END;
          else          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_SEP: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_SEP;
          cmd.last  = fin_r;
          state_nxt = S_END;
        end
      end
      S_DRV_LETTER: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_LETTER;
          state_nxt = S_DRV_COLON;
        end
      end
      S_DRV_COLON: begin
        if (st.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_COLON;
          cmd.last  = fin_r;
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd.clear = drive_r || flush_r || fin_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/ptsf_dp.sv @@
module ptsf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 allow_spaces,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  ptsf_pkg::ptsf_cmd_t  cmd,
  output ptsf_pkg::ptsf_stat_t st,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast
);
  import ptsf_pkg::*;

  logic [1:0]             pos_r, pos_nxt;
  logic [COUNT_WIDTH-1:0] len_r, len_nxt;
  logic                   dot_f_r, dot_f_nxt;
  logic [COUNT_WIDTH-1:0] dot_off_r, dot_off_nxt;
  logic                   us_f_r, us_f_nxt;
  logic [COUNT_WIDTH-1:0] us_off_r, us_off_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic [7:0]             sep_byte_r;
  logic [7:0]             head_r  [BASE_CHARS];
  logic [7:0]             dtail_r [TAIL_CHARS];
  logic [7:0]             utail_r [TAIL_CHARS];

  logic                   letter, do_add;
  logic [COUNT_WIDTH-1:0] d, rem, rem1, src, dpos, upos;
  logic                   have;
  logic [7:0]             tail_byte, emit_byte;

  assign letter = ((in_tdata >= 8'h41) && (in_tdata <= 8'h5A)) ||
                  ((in_tdata >= 8'h61) && (in_tdata <= 8'h7A));
  assign st.is_drive = (pos_r == POS_LETTER) && (in_tdata == CH_COLON);
  assign st.is_sep   = (in_tdata == CH_SLASH) || (in_tdata == CH_BSLASH);
  assign do_add = cmd.accept && !st.is_drive && !st.is_sep && (len_r != COUNT_MAX);

  // where the current byte lands relative to each extension point
  assign dpos = len_r - dot_off_r - COUNT_WIDTH'(1);
  assign upos = len_r - us_off_r - COUNT_WIDTH'(1);

  // flush plan, from the registered component state
  assign have = dot_f_r || us_f_r;
  assign d    = dot_f_r ? dot_off_r : us_off_r;
  assign rem  = len_r - d;
  assign rem1 = rem - COUNT_WIDTH'(1);
  assign st.split = have && (d != '0) &&
                    ((rem <= COUNT_WIDTH'(EXT_CHARS)) ||
                     ((len_r > COUNT_WIDTH'(BASE_CHARS)) && (d > COUNT_WIDTH'(TAIL_CHARS))));
  assign st.one = have && (len_r == COUNT_WIDTH'(1));
  assign src = st.split ? d : len_r;
  assign st.n_head = (src < COUNT_WIDTH'(BASE_CHARS)) ? src[HEAD_NW-1:0] : HEAD_NW'(BASE_CHARS);
  assign st.n_tail = (rem1 < COUNT_WIDTH'(TAIL_CHARS)) ? rem1[TAIL_NW-1:0]
                                                       : TAIL_NW'(TAIL_CHARS);
  assign st.slot_free = !out_valid_r || out_tready;

  always_comb begin
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    dot_f_nxt   = dot_f_r;
    dot_off_nxt = dot_off_r;
    us_f_nxt    = us_f_r;
    us_off_nxt  = us_off_r;
    if (cmd.accept) begin
      if (in_tlast)                              pos_nxt = POS_START;
      else if (!st.is_drive && pos_r == POS_START && letter) pos_nxt = POS_LETTER;
      else                                       pos_nxt = POS_BODY;
    end
    if (do_add) begin
      if (in_tdata == CH_DOT) begin
        dot_f_nxt   = 1'b1;
        dot_off_nxt = len_r;
      end
      if (in_tdata == CH_USCORE) begin
        us_f_nxt   = 1'b1;
        us_off_nxt = len_r;
      end
      len_nxt = len_r + COUNT_WIDTH'(1);
    end
    if (cmd.clear) begin
      len_nxt     = '0;
      dot_f_nxt   = 1'b0;
      dot_off_nxt = '0;
      us_f_nxt    = 1'b0;
      us_off_nxt  = '0;
    end
  end

  assign tail_byte = dot_f_r ? dtail_r[cmd.idx[TAIL_IW-1:0]] : utail_r[cmd.idx[TAIL_IW-1:0]];

  always_comb begin
    case (cmd.sel)
      EM_HEAD:   emit_byte = body_char(head_r[cmd.idx[HEAD_IW-1:0]], allow_spaces);
      EM_DOT:    emit_byte = CH_DOT;
      EM_TAIL:   emit_byte = body_char(tail_byte, allow_spaces);
      EM_SEP:    emit_byte = map_char(sep_byte_r, allow_spaces);
      EM_LETTER: emit_byte = head_r[0];
      EM_COLON:  emit_byte = CH_COLON;
      default:   emit_byte = CH_USCORE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_START;
      len_r       <= '0;
      dot_f_r     <= 1'b0;
      dot_off_r   <= '0;
      us_f_r      <= 1'b0;
      us_off_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      dot_f_r     <= dot_f_nxt;
      dot_off_r   <= dot_off_nxt;
      us_f_r      <= us_f_nxt;
      us_off_r    <= us_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) sep_byte_r <= in_tdata;
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
    end
    if (do_add) begin
      if (len_r < COUNT_WIDTH'(BASE_CHARS)) head_r[len_r[HEAD_IW-1:0]] <= in_tdata;
      if (dot_f_r && dpos < COUNT_WIDTH'(TAIL_CHARS)) dtail_r[dpos[TAIL_IW-1:0]] <= in_tdata;
      if (us_f_r && upos < COUNT_WIDTH'(TAIL_CHARS))  utail_r[upos[TAIL_IW-1:0]] <= in_tdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/path_to_short_filename_top.sv @@
// Path to 8.3 short-name converter.
// Input stream: one path character per item, in_tdata[7:0] = path_byte,
// in_tlast = final_byte (last character of the path).
// Output stream: out_tdata[7:0] = out_byte, out_tlast = out_final, set on the
// last output character produced for the final input character.
// The block works on one item at a time. A plain character passes through
// accept, plan and clear. A separator or the final character flushes the
// buffered component, emitting at most 13 characters through the single
// output register.
// A drive prefix ("C:") emits two characters when the colon arrives.
// A stalled receiver holds the output register; the sequencer waits on it and
// no input is taken until the current item's characters are all loaded.
// Reset (synchronous, active low) returns to the start of a path, empties the
// output register and clears allow_spaces. allow_spaces sits at APB address 0,
// bit 0, and must be written only while the block is idle; the block does not enforce it.
module path_to_short_filename_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,  // [7:0] path_byte
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata, // [7:0] out_byte
  output logic                         out_tlast,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ptsf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import ptsf_pkg::*;
  `include "path_to_short_filename_top_macros.svh"

  logic       allow_r, allow_nxt;
  logic       cfg_wr;
  ptsf_cmd_t  cmd;
  ptsf_stat_t st;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == CFG_ADDR_ALLOW_SPACES);
  assign allow_nxt  = cfg_wr ? cfg_pwdata[0] : allow_r;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_ALLOW_SPACES) ? {31'b0, allow_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) allow_r <= 1'b0;
    else        allow_r <= allow_nxt;
  end

  ptsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ptsf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .allow_spaces (allow_r),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .cmd          (cmd),
    .st           (st),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

  `PTSF_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `PTSF_ASSERT_NEXT(a_cfg_write_lands, cfg_wr, allow_r == $past(cfg_pwdata[0]), "allow_spaces not written")
  `PTSF_ASSERT_NEXT(a_emit_needs_slot, cmd.emit && !st.slot_free, 1'b0, "output overwritten")
  `PTSF_ASSERT_AFTER_RST(a_reset_empty, !out_tvalid && in_tready, "output not empty after reset")

endmodule

@@ test/path_to_short_filename_top_tb.sv @@
`timescale 1ns / 1ps

module path_to_short_filename_top_tb;
  import ptsf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                out_tlast;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [31:0]         cfg_pwdata;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  path_to_short_filename_top u_top (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // shadow of the converter
  logic        sp_allow;
  logic [1:0]  sp_pos;
  int unsigned sp_len;
  logic [7:0]  sp_head [BASE_CHARS];
  logic        sp_dot_seen;
  int unsigned sp_dot_at;
  logic [7:0]  sp_dot_tail [TAIL_CHARS];
  logic        sp_us_seen;
  int unsigned sp_us_at;
  logic [7:0]  sp_us_tail [TAIL_CHARS];

  char_t pending_chars [$];
  char_t short_chars [$];
  int    n_fail;
  int    n_mismatch;
  bit    stim_done;

  function automatic logic [7:0] shorten_map(logic [7:0] c);
    case (c)
      ":", ";", ",", "=", "+", "\"", "[", "]", "<", ">", "|", 8'h09: return CH_USCORE;
      CH_SPACE: return sp_allow ? CH_SPACE : CH_USCORE;
      default: return c;
    endcase
  endfunction

  function automatic void shorten_put(logic [7:0] c);
    short_chars.push_back('{ch: c, fin: 1'b0});
  endfunction

  function automatic void shorten_body(logic [7:0] c);
    shorten_put(shorten_map(c == CH_DOT ? CH_USCORE : c));
  endfunction

  function automatic void comp_clear();
    sp_len = 0;
    sp_dot_seen = 0;
    sp_dot_at = 0;
    sp_us_seen = 0;
    sp_us_at = 0;
    foreach (sp_head[i]) sp_head[i] = 8'd0;
    foreach (sp_dot_tail[i]) begin
      sp_dot_tail[i] = 8'd0;
      sp_us_tail[i] = 8'd0;
    end
  endfunction

  function automatic void comp_add(logic [7:0] b);
    int unsigned p;
    p = sp_len;
    if (p >= COUNT_MAX) return;
    if (p < BASE_CHARS) sp_head[p] = b;
    if (sp_dot_seen && (p - sp_dot_at - 1) < TAIL_CHARS) sp_dot_tail[p - sp_dot_at - 1] = b;
    if (sp_us_seen && (p - sp_us_at - 1) < TAIL_CHARS) sp_us_tail[p - sp_us_at - 1] = b;
    if (b == CH_DOT) begin
      sp_dot_seen = 1;
      sp_dot_at = p;
    end
    if (b == CH_USCORE) begin
      sp_us_seen = 1;
      sp_us_at = p;
    end
    sp_len = p + 1;
  endfunction

  function automatic void comp_flush();
    bit          have;
    int unsigned d;
    int unsigned n;
    have = sp_dot_seen || sp_us_seen;
    d = sp_dot_seen ? sp_dot_at : sp_us_at;
    if (have && d > 0 && ((sp_len - d <= EXT_CHARS) ||
        (sp_len > BASE_CHARS && d > TAIL_CHARS))) begin
      n = d < BASE_CHARS ? d : BASE_CHARS;
      for (int i = 0; i < n; i++) shorten_body(sp_head[i]);
      shorten_put(CH_DOT);
      n = sp_len - d - 1;
      if (n > TAIL_CHARS) n = TAIL_CHARS;
      for (int i = 0; i < n; i++)
        shorten_body(sp_dot_seen ? sp_dot_tail[i] : sp_us_tail[i]);
    end else if (have && sp_len == 1) begin
      shorten_put(CH_DOT);
    end else begin
      n = sp_len < BASE_CHARS ? sp_len : BASE_CHARS;
      for (int i = 0; i < n; i++) shorten_body(sp_head[i]);
    end
    comp_clear();
  endfunction

  function automatic void shorten_step(char_t it);
    int  before_n;
    bit  letter;
    before_n = short_chars.size();
    letter = (it.ch >= "A" && it.ch <= "Z") || (it.ch >= "a" && it.ch <= "z");
    if (sp_pos == POS_LETTER && it.ch == CH_COLON) begin
      shorten_put(sp_head[0]);
      shorten_put(CH_COLON);
      comp_clear();
      sp_pos = POS_BODY;
    end else begin
      sp_pos = (sp_pos == POS_START && letter) ? POS_LETTER : POS_BODY;
      if (it.ch == CH_SLASH || it.ch == CH_BSLASH) begin
        comp_flush();
        shorten_put(shorten_map(it.ch));
      end else begin
        comp_add(it.ch);
        if (it.fin) comp_flush();
      end
    end
    if (it.fin) begin
      if (short_chars.size() > before_n) short_chars[short_chars.size()-1].fin = 1'b1;
      sp_pos = POS_START;
      comp_clear();
    end
  endfunction

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        shorten_step('{ch: in_tdata, fin: in_tlast});
        pending_chars.pop_front();
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        // head of queue is the item in flight until accepted
        char_t nxt;
        nxt = pending_chars[0];
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.ch;
        in_tlast  <= nxt.fin;
        in_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap;
  int out_draw;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (short_chars.size() == 0) begin
          n_fail++;
          if (n_mismatch++ < 10)
            $display("unexpected item %h last %b", out_tdata, out_tlast);
        end else begin
          char_t e;
          e = short_chars.pop_front();
          if (e.ch !== out_tdata || e.fin !== out_tlast) begin
            n_fail++;
            if (n_mismatch++ < 10)
              $display("mismatch: expected %h/%b, got %h/%b", e.ch, e.fin, out_tdata,
                       out_tlast);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        out_draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        out_gap    <= (out_draw > 0) ? out_draw - 1 : 0;
        out_tready <= (out_draw == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (!stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("FAIL path_to_short_filename_top");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sp_allow = data[0];
  endtask

  task automatic push_path(string s);
    for (int i = 0; i < s.len(); i++)
      pending_chars.push_back('{ch: s[i], fin: (i == s.len() - 1)});
  endtask

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return CH_DOT;
      2: return CH_USCORE;
      3: return $urandom_range(0, 1) ? CH_SLASH : CH_BSLASH;
      4: return CH_SPACE;
      5: begin
        case ($urandom_range(0, 5))
          0: return ":";
          1: return "+";
          2: return "|";
          3: return 8'h09;
          4: return "\"";
          default: return "[";
        endcase
      end
      default: return $urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                            : 8'($urandom_range("0", "9"));
    endcase
  endfunction

  // well-formed paths with random content, plus some raw noise
  task automatic push_random(int n_items);
    int left;
    left = n_items;
    while (left > 0) begin
      int n;
      string s;
      s = "";
      if ($urandom_range(0, 1)) begin
        s = {s, string'(8'($urandom_range("A", "Z"))), ":"};
        if ($urandom_range(0, 1)) s = {s, "\\"};
      end
      n = $urandom_range(1, 3);
      for (int c = 0; c < n; c++) begin
        int k;
        k = $urandom_range(0, 3) == 0 ? $urandom_range(9, 14) : $urandom_range(1, 8);
        for (int j = 0; j < k; j++) s = {s, string'(rand_char())};
        if (c < n - 1 || $urandom_range(0, 4) == 0) s = {s, "/"};
      end
      if (s.len() > left) s = s.substr(0, left - 1);
      push_path(s);
      left -= s.len();
    end
  endtask

  task automatic settle();
    stim_done = 0;
    while (pending_chars.size() > 0 || short_chars.size() > 0) @(posedge clk);
    stim_done = 1;
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sp_allow    = 1'b0;
    sp_pos      = POS_START;
    n_fail      = 0;
    n_mismatch  = 0;
    stim_done   = 1;
    comp_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: drive, long names, dot/underscore split, lone dot, mapping, ':' later
    push_path("C:\\PROGRA~1/longfilename.text");
    push_path("a b;c.d\\.\\_/x:y");
    push_path("readme.htm");
    push_path("my_file_name");
    pending_chars.push_back('{ch: 8'hFF, fin: 1'b0});
    pending_chars.push_back('{ch: 8'h00, fin: 1'b1});
    push_path("z/");
    settle();

    cfg_write(CFG_ADDR_ALLOW_SPACES, 32'd1);
    push_path("d:a b.c d");
    push_random(70);
    settle();

    cfg_write(CFG_ADDR_ALLOW_SPACES, 32'd0);
    push_random(80);
    settle();

    if (n_fail == 0) begin
      $display("PASS path_to_short_filename_top");
    end else begin
      $display("FAIL path_to_short_filename_top");
    end
    $finish;
  end

endmodule
